// ===== design/rcfe_pkg.sv =====
// ----------------------------------------------------------------------------
// rcfe_pkg: shared types and constants of the rc channel frame encoder
// Holds the frame constants, the queued channel item and the crc-8 helper.
// ----------------------------------------------------------------------------
`default_nettype none

package rcfe_pkg;

  // pulse width limits and offset of the microsecond to channel mapping
  localparam logic [15:0] UsMin    = 16'd1000;
  localparam logic [15:0] UsMax    = 16'd2000;
  localparam logic [15:0] UsOffset = 16'd988;

  // frame layout
  localparam logic [7:0]  FrameLen         = 8'd24;
  localparam logic [4:0]  ChannelsPerFrame = 5'd16;
  localparam logic [10:0] CenterValue      = 11'd768;
  localparam logic [7:0]  CrcPoly          = 8'hD5;

  // configuration register indexes
  localparam int unsigned CfgIndexW   = 8;
  localparam logic [CfgIndexW-1:0] CfgDeviceAddress = 8'd0;
  localparam logic [CfgIndexW-1:0] CfgFrameType     = 8'd1;

  // default depth of the queue between front and back
  localparam int unsigned QueueDepthDefault = 4;

  // one classified channel waiting for the packer
  typedef struct packed {
    logic        last;
    logic [10:0] value;
  } chan_item_t;

  // configuration registers seen by the packer
  typedef struct packed {
    logic [7:0] device_address;
    logic [7:0] frame_type;
  } cfg_regs_t;

  // crc-8, polynomial 0xD5, one byte msb first
  function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] data);
    logic [7:0] c;
    c = crc ^ data;
    for (int i = 0; i < 8; i++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ CrcPoly;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// ===== design/rcfe_front.sv =====
// ----------------------------------------------------------------------------
// rcfe_front: channel intake
// Accepts pulse widths, clamps them to 1000..2000 us and maps them to the
// 11-bit channel value floor((us - 988) * 3 / 2) for the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module rcfe_front
  import rcfe_pkg::*;
(
  input  wire logic        s_axis_tvalid_i,
  output      logic        s_axis_tready_o,
  input  wire logic [15:0] s_axis_tdata_i,   // channel_us[15:0]
  input  wire logic        s_axis_tlast_i,   // last_channel
  input  wire logic        q_full_i,
  output      logic        q_push_o,
  output      chan_item_t  q_item_o
);

  logic [15:0] us_clamped;
  logic [10:0] us_delta;
  logic [11:0] triple;

  // accept whenever the queue has room
  assign s_axis_tready_o = !q_full_i;
  assign q_push_o        = s_axis_tvalid_i && !q_full_i;

  // clamp to the legal pulse range
  always_comb begin
    if (s_axis_tdata_i < UsMin) begin
      us_clamped = UsMin;
    end else if (s_axis_tdata_i > UsMax) begin
      us_clamped = UsMax;
    end else begin
      us_clamped = s_axis_tdata_i;
    end
  end

  // times three by shift and add, then halve
  assign us_delta = 11'(us_clamped - UsOffset);
  assign triple   = {1'b0, us_delta} + {us_delta, 1'b0};

  assign q_item_o.value = triple[11:1];
  assign q_item_o.last  = s_axis_tlast_i;

endmodule

`default_nettype wire

// ===== design/rcfe_queue.sv =====
// ----------------------------------------------------------------------------
// rcfe_queue: channel queue
// Small first-in first-out store that decouples intake from the packer.
// ----------------------------------------------------------------------------
`default_nettype none

module rcfe_queue
  import rcfe_pkg::*;
#(
  parameter int unsigned Depth = QueueDepthDefault
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       push_i,
  input  chan_item_t      item_i,
  output      logic       full_o,
  output      logic       valid_o,
  output      chan_item_t item_o,
  input  wire logic       pop_i
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  chan_item_t            mem_q [Depth];
  logic [PtrW-1:0]       wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]       rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]       count_q, count_d;

  assign full_o  = (count_q == CntW'(Depth));
  assign valid_o = (count_q != '0);
  assign item_o  = mem_q[rd_ptr_q];

  // pointer wrap and fill count
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (!push_i && pop_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

`default_nettype wire

// ===== design/rcfe_back.sv =====
// ----------------------------------------------------------------------------
// rcfe_back: frame sequencer and bit packer
// Sends the header, packs channel values lsb first into bytes, fills missing
// channels with center, keeps the running crc and sends it as the last byte.
// ----------------------------------------------------------------------------
`default_nettype none

module rcfe_back
  import rcfe_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  cfg_regs_t       cfg_i,
  input  wire logic       q_valid_i,
  input  chan_item_t      q_item_i,
  output      logic       q_pop_o,
  output      logic       m_axis_tvalid_o,
  input  wire logic       m_axis_tready_i,
  output      logic [7:0] m_axis_tdata_o,  // frame_byte[7:0]
  output      logic       m_axis_tlast_o   // end_of_frame
);

  typedef enum logic [2:0] {
    S_ADDR,
    S_LEN,
    S_TYPE,
    S_PACK,
    S_CRC
  } state_e;

  state_e      state_q, state_d;
  logic [4:0]  cnt_q, cnt_d;
  logic [17:0] buf_q, buf_d;
  logic [4:0]  held_q, held_d;
  logic [7:0]  crc_q, crc_d;
  logic        close_q, close_d;
  logic        out_valid_q, out_valid_d;
  logic [7:0]  out_data_q, out_data_d;
  logic        out_last_q, out_last_d;

  logic        can_push;
  logic        emit;
  logic [17:0] buf_e;
  logic [4:0]  held_e;
  logic [10:0] ins_value;

  // output register frees when empty or taken
  assign can_push = !out_valid_q || m_axis_tready_i;
  assign emit     = (held_q >= 5'd8);

  // buffer after the byte that goes out this cycle
  always_comb begin
    if (emit) begin
      buf_e  = {8'd0, buf_q[17:8]};
      held_e = held_q - 5'd8;
    end else begin
      buf_e  = buf_q;
      held_e = held_q;
    end
  end

  assign ins_value = close_q ? CenterValue : q_item_i.value;

  // sequencer
  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    buf_d       = buf_q;
    held_d      = held_q;
    crc_d       = crc_q;
    close_d     = close_q;
    out_valid_d = out_valid_q && !m_axis_tready_i;
    out_data_d  = out_data_q;
    out_last_d  = out_last_q;
    q_pop_o     = 1'b0;
    case (state_q)
      S_ADDR: begin
        if (q_valid_i && can_push) begin
          out_valid_d = 1'b1;
          out_data_d  = cfg_i.device_address;
          out_last_d  = 1'b0;
          state_d     = S_LEN;
        end
      end
      S_LEN: begin
        if (can_push) begin
          out_valid_d = 1'b1;
          out_data_d  = FrameLen;
          out_last_d  = 1'b0;
          state_d     = S_TYPE;
        end
      end
      S_TYPE: begin
        // type byte goes out while the first channel enters the buffer
        if (can_push) begin
          out_valid_d = 1'b1;
          out_data_d  = cfg_i.frame_type;
          out_last_d  = 1'b0;
          crc_d       = crc8_byte(8'd0, cfg_i.frame_type);
          q_pop_o     = 1'b1;
          buf_d       = {7'd0, q_item_i.value};
          held_d      = 5'd11;
          cnt_d       = 5'd1;
          close_d     = q_item_i.last;
          state_d     = S_PACK;
        end
      end
      S_PACK: begin
        if (!emit || can_push) begin
          if (emit) begin
            out_valid_d = 1'b1;
            out_data_d  = buf_q[7:0];
            out_last_d  = 1'b0;
            crc_d       = crc8_byte(crc_q, buf_q[7:0]);
          end
          buf_d  = buf_e;
          held_d = held_e;
          // refill with the next channel or a center fill
          if (held_e < 5'd8) begin
            if ((!close_q && q_valid_i) || (close_q && cnt_q < ChannelsPerFrame)) begin
              q_pop_o = !close_q;
              buf_d   = buf_e | ({7'd0, ins_value} << held_e[2:0]);
              held_d  = held_e + 5'd11;
              cnt_d   = cnt_q + 5'd1;
              close_d = close_q || q_item_i.last || (cnt_q + 5'd1 == ChannelsPerFrame);
            end else if (close_q) begin
              state_d = S_CRC;
            end
          end
        end
      end
      S_CRC: begin
        if (can_push) begin
          out_valid_d = 1'b1;
          out_data_d  = crc_q;
          out_last_d  = 1'b1;
          cnt_d       = '0;
          buf_d       = '0;
          held_d      = '0;
          crc_d       = '0;
          close_d     = 1'b0;
          state_d     = S_ADDR;
        end
      end
      default: begin
        state_d = S_ADDR;
      end
    endcase
  end

  // state and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_ADDR;
      cnt_q       <= '0;
      buf_q       <= '0;
      held_q      <= '0;
      crc_q       <= '0;
      close_q     <= 1'b0;
      out_valid_q <= 1'b0;
      out_data_q  <= '0;
      out_last_q  <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      buf_q       <= buf_d;
      held_q      <= held_d;
      crc_q       <= crc_d;
      close_q     <= close_d;
      out_valid_q <= out_valid_d;
      out_data_q  <= out_data_d;
      out_last_q  <= out_last_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tlast_o  = out_last_q;

  // buffer never holds more than one byte plus one channel
  assert property (@(posedge clk_i) disable iff (!rst_ni) held_q <= 5'd18)
    else $error("bit buffer overfilled");

  // crc byte only after exactly sixteen channels fully drained
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CRC) |-> (held_q == 5'd0 && cnt_q == ChannelsPerFrame))
    else $error("crc reached with bits or channels outstanding");

  // a pop only when the queue holds an item
  assert property (@(posedge clk_i) disable iff (!rst_ni) q_pop_o |-> q_valid_i)
    else $error("pop from empty queue");

  // the end flag leaves the sequencer back at the frame start
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CRC && can_push) |=> (state_q == S_ADDR && m_axis_tlast_o))
    else $error("frame end out of step");

endmodule

`default_nettype wire

// ===== design/rc_channel_frame_encoder.sv =====
// ----------------------------------------------------------------------------
// rc_channel_frame_encoder: rc channels frame encoder
// Packs servo pulse widths into 26-byte rc channels frames with crc-8.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis: one channel per transaction, tdata = pulse width in us, tlast
//   marks the last supplied channel of a frame. m_axis: one frame byte per
//   transaction, tlast on the crc byte. cfg: register writes (index 0
//   device address, index 1 frame type), always ready, read as the
//   header bytes of a frame are sent; other indexes are ignored.
//   A frame is address, 24, type, 22 payload bytes and crc. It closes at the
//   16th channel or at tlast; missing channels are sent as center 768.
// On an idle encoder the queue stores the first channel of a frame at the
//   edge that accepts it, and the first header byte enters the output
//   register at the next edge.
// Throughput: the back end moves one byte per cycle while the receiver is
//   ready and queued channels are on hand; the input takes one channel per
//   cycle until the queue is full.
// Reset: registers return to address 238 and type 22, queue empty, no frame
//   open. When the receiver stalls the output byte holds, the queue fills,
//   and then s_axis_tready_o drops.
// ----------------------------------------------------------------------------
`default_nettype none

module rc_channel_frame_encoder
  import rcfe_pkg::*;
#(
  parameter int unsigned QueueDepth = QueueDepthDefault
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 s_axis_tvalid_i,
  output      logic                 s_axis_tready_o,
  input  wire logic [15:0]          s_axis_tdata_i,   // channel_us[15:0]
  input  wire logic                 s_axis_tlast_i,   // last_channel
  output      logic                 m_axis_tvalid_o,
  input  wire logic                 m_axis_tready_i,
  output      logic [7:0]           m_axis_tdata_o,   // frame_byte[7:0]
  output      logic                 m_axis_tlast_o,   // end_of_frame
  input  wire logic                 cfg_valid_i,
  output      logic                 cfg_ready_o,
  input  wire logic [CfgIndexW-1:0] cfg_index_i,
  input  wire logic [7:0]           cfg_data_i
);

  cfg_regs_t  cfg_q;
  logic       q_push;
  logic       q_full;
  logic       q_valid;
  logic       q_pop;
  chan_item_t q_in;
  chan_item_t q_out;

  // configuration registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.device_address <= 8'd238;
      cfg_q.frame_type     <= 8'd22;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CfgDeviceAddress: cfg_q.device_address <= cfg_data_i;
        CfgFrameType:     cfg_q.frame_type     <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // intake and classification
  rcfe_front u_front (
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tlast_i  (s_axis_tlast_i),
    .q_full_i        (q_full),
    .q_push_o        (q_push),
    .q_item_o        (q_in)
  );

  // queue between intake and packer
  rcfe_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .item_i  (q_in),
    .full_o  (q_full),
    .valid_o (q_valid),
    .item_o  (q_out),
    .pop_i   (q_pop)
  );

  // frame sequencer
  rcfe_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_i           (cfg_q),
    .q_valid_i       (q_valid),
    .q_item_i        (q_out),
    .q_pop_o         (q_pop),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

endmodule

`default_nettype wire
